FILE: hdl/star_polygon_vertex_generator_core_defines.svh
// Assertion macros shared by the checker of the star polygon vertex generator.
// No dependencies; included by the checker file only.
`ifndef STAR_POLYGON_VERTEX_GENERATOR_CORE_DEFINES_SVH
`define STAR_POLYGON_VERTEX_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPVG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spvg same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spvg next-cycle check failed");

`endif

FILE: hdl/spvg_pkg.sv
// Types, constants and the arctangent table of the star polygon vertex generator.
// No dependencies; used by the top, front and back modules of the block.
`default_nettype none
package spvg_pkg;

   localparam int CORDIC_ITERS = 24;
   localparam int TRIG_W       = 34;
   localparam int PROD_W       = 58;
   localparam int COORD_W      = 24;
   localparam int RADIUS_W     = 23;
   localparam int COUNT_W      = 6;
   localparam int REM_W        = 8;

   localparam logic signed [TRIG_W-1:0] INV_GAIN = 34'sd652032874;
   localparam logic signed [COORD_W+4:0] COORD_MAX = 29'sd8388607;
   localparam logic signed [COORD_W+4:0] COORD_MIN = -29'sd8388608;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic [RADIUS_W-1:0]       valley_radius;
      logic [RADIUS_W-1:0]       tip_radius;
      logic [COUNT_W-1:0]        point_count;
   } desc_type;

   function automatic logic [29:0] atan_turn(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:  val = 30'd536870912;
         5'd1:  val = 30'd316933406;
         5'd2:  val = 30'd167458907;
         5'd3:  val = 30'd85004756;
         5'd4:  val = 30'd42667331;
         5'd5:  val = 30'd21354465;
         5'd6:  val = 30'd10680862;
         5'd7:  val = 30'd5340245;
         5'd8:  val = 30'd2670163;
         5'd9:  val = 30'd1335087;
         5'd10: val = 30'd667544;
         5'd11: val = 30'd333772;
         5'd12: val = 30'd166886;
         5'd13: val = 30'd83443;
         5'd14: val = 30'd41722;
         5'd15: val = 30'd20861;
         5'd16: val = 30'd10430;
         5'd17: val = 30'd5215;
         5'd18: val = 30'd2608;
         5'd19: val = 30'd1304;
         5'd20: val = 30'd652;
         5'd21: val = 30'd326;
         5'd22: val = 30'd163;
         5'd23: val = 30'd81;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/star_polygon_vertex_generator_core.sv
// Top level of the star polygon vertex generator: front, queue and back.
// Depends on spvg_pkg, spvg_front, spvg_queue and spvg_back.
//
//   Channel   Ports             Handshake
//   request   start, req_*      taken when start is high and busy is low
//   result    rsp_*             one cycle per vertex, marked by rsp_strobe
//
// A request is accepted, has its angle step divided into ANGLE_BITS-1 quotient
// bits by the serial angle-step divider and then waits to enter a two-entry queue.
// Each vertex passes through the back end in a setup step, the 24 iterations of the
// single CORDIC rotator, a multiply step and a sum step.
// A request of N points gives 2*N vertices. Reset is synchronous and clears all control state.
// The receiver cannot stall; busy stays high while the front end holds an item.
`default_nettype none
module star_polygon_vertex_generator_core #(
   parameter int MAX_POINTS = 32,
   parameter int ANGLE_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [23:0] req_center_x,
   input  wire logic signed [23:0] req_center_y,
   input  wire logic [22:0]        req_valley_radius,
   input  wire logic [22:0]        req_tip_radius,
   input  wire logic [5:0]         req_point_count,
   output logic                    rsp_strobe,
   output logic signed [23:0]      rsp_vertex_x,
   output logic signed [23:0]      rsp_vertex_y,
   output logic                    rsp_is_outer,
   output logic                    rsp_last_vertex
);
   localparam int SQW = ANGLE_BITS - 1;
   localparam int RW  = spvg_pkg::REM_W;
   localparam int DW  = $bits(spvg_pkg::desc_type);
   localparam int QW  = DW + SQW + RW;

   spvg_pkg::desc_type req_desc, push_desc, pop_desc;
   logic [SQW-1:0]     push_step_q, pop_step_q;
   logic [RW-1:0]      push_step_r, pop_step_r;
   logic               push_valid, q_full, q_empty, q_pop;
   logic [QW-1:0]      pop_data;

   always_comb begin
      req_desc.center_x      = req_center_x;
      req_desc.center_y      = req_center_y;
      req_desc.valley_radius = req_valley_radius;
      req_desc.tip_radius    = req_tip_radius;
      req_desc.point_count   = req_point_count;
   end

   spvg_front #(.MAX_POINTS(MAX_POINTS), .ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_desc    (req_desc),
      .push_desc   (push_desc),
      .push_step_q (push_step_q),
      .push_step_r (push_step_r),
      .push_valid  (push_valid),
      .push_full   (q_full)
   );

   spvg_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_desc, push_step_q, push_step_r}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   assign pop_desc   = pop_data[QW-1 -: DW];
   assign pop_step_q = pop_data[RW +: SQW];
   assign pop_step_r = pop_data[RW-1:0];

   spvg_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_desc          (pop_desc),
      .q_step_q        (pop_step_q),
      .q_step_r        (pop_step_r),
      .rsp_strobe      (rsp_strobe),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_is_outer    (rsp_is_outer),
      .rsp_last_vertex (rsp_last_vertex)
   );
endmodule
`default_nettype wire

FILE: hdl/spvg_front.sv
// Front end: accepts a request, clamps the point count and divides one angle
// step by the point count serially. Depends on spvg_pkg.
`default_nettype none
module spvg_front #(
   parameter int MAX_POINTS = 32,
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire spvg_pkg::desc_type           req_desc,
   output spvg_pkg::desc_type                push_desc,
   output logic [ANGLE_BITS-2:0]             push_step_q,
   output logic [spvg_pkg::REM_W-1:0]        push_step_r,
   output logic                              push_valid,
   input  wire logic                         push_full
);
   localparam int CW = $clog2(ANGLE_BITS - 1);
   localparam int NW = spvg_pkg::COUNT_W;

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_type;

   fstate_type              state_ff;
   spvg_pkg::desc_type      desc_ff;
   spvg_pkg::desc_type      desc_in;
   logic [ANGLE_BITS-2:0]   quo_ff;
   logic [NW-1:0]           rem_ff;
   logic [CW-1:0]           cnt_ff;
   logic [NW-1:0]           n_in;
   logic [NW:0]             shifted;
   logic                    qbit;
   logic [NW-1:0]           rem_in;

   always_comb begin
      if (req_desc.point_count == '0) begin
         n_in = NW'(1);
      end else if (req_desc.point_count > NW'(MAX_POINTS)) begin
         n_in = NW'(MAX_POINTS);
      end else begin
         n_in = req_desc.point_count;
      end
      desc_in             = req_desc;
      desc_in.point_count = n_in;
      shifted = {rem_ff, (cnt_ff == CW'(ANGLE_BITS - 2))};
      qbit    = (shifted >= {1'b0, desc_ff.point_count});
      rem_in  = qbit ? NW'(shifted - {1'b0, desc_ff.point_count}) : shifted[NW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (start) begin
                  desc_ff  <= desc_in;
                  quo_ff   <= '0;
                  rem_ff   <= '0;
                  cnt_ff   <= CW'(ANGLE_BITS - 2);
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               quo_ff <= {quo_ff[ANGLE_BITS-3:0], qbit};
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == '0) begin
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!push_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign busy        = (state_ff != F_IDLE);
   assign push_valid  = (state_ff == F_PUSH);
   assign push_desc   = desc_ff;
   assign push_step_q = quo_ff;
   assign push_step_r = {rem_ff, 2'b00};
endmodule
`default_nettype wire

FILE: hdl/spvg_queue.sv
// Two-entry queue that carries prepared requests from the front to the back.
// No package dependencies.
`default_nettype none
module spvg_queue #(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   output logic              full,
   input  wire logic         pop,
   output logic [W-1:0]      pop_data,
   output logic              empty
);
   logic [W-1:0] mem_ff [2];
   logic         wr_ff;
   logic         rd_ff;
   logic [1:0]   cnt_ff;
   logic         do_push;
   logic         do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ff <= !wr_ff;
         end
         if (do_pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end
endmodule
`default_nettype wire

FILE: hdl/spvg_back.sv
// Back end: steps the vertex angle, runs a shared CORDIC rotator, scales by the
// radius, adds the center and saturates. Depends on spvg_pkg.
`default_nettype none
module spvg_back #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_empty,
   output logic                             q_pop,
   input  wire spvg_pkg::desc_type          q_desc,
   input  wire logic [ANGLE_BITS-2:0]       q_step_q,
   input  wire logic [spvg_pkg::REM_W-1:0]  q_step_r,
   output logic                             rsp_strobe,
   output logic signed [23:0]               rsp_vertex_x,
   output logic signed [23:0]               rsp_vertex_y,
   output logic                             rsp_is_outer,
   output logic                             rsp_last_vertex
);
   localparam int A  = ANGLE_BITS;
   localparam int TW = spvg_pkg::TRIG_W;
   localparam int PW = spvg_pkg::PROD_W;
   localparam int RW = spvg_pkg::REM_W;
   localparam int NW = spvg_pkg::COUNT_W;

   typedef enum logic [2:0] {B_IDLE, B_PREP, B_ROT, B_MUL, B_SUM} bstate_type;

   bstate_type              state_ff;
   spvg_pkg::desc_type      desc_ff;
   logic [A-2:0]            sq_ff;
   logic [RW-1:0]           sr_ff;
   logic [A-1:0]            pq_ff;
   logic [RW-1:0]           pr_ff;
   logic [NW-1:0]           j_ff;
   logic [4:0]              iter_ff;
   logic [1:0]              quad_ff;
   logic signed [TW-1:0]    x_ff, y_ff, z_ff;
   logic signed [PW-1:0]    pc_ff, ps_ff;
   logic                    strobe_ff;
   logic signed [23:0]      vx_ff, vy_ff;
   logic                    outer_ff, last_ff;

   logic [RW-1:0]           den4;
   logic [RW-1:0]           init_r;
   logic [RW-1:0]           adv_r;
   logic [31:0]             phase32;
   logic [1:0]              quad_in;
   logic [31:0]             resid;
   logic signed [TW-1:0]    dx, dy, atan_s;
   logic signed [TW-1:0]    c_val, s_val;
   logic signed [24:0]      radius_s;
   logic signed [PW-1:0]    rnd_x, rnd_y;
   logic signed [28:0]      sum_x, sum_y;
   logic signed [23:0]      sat_x, sat_y;
   logic                    is_last;

   always_comb begin
      den4     = {desc_ff.point_count, 2'b00};
      init_r   = q_step_r + {1'b0, q_desc.point_count, 1'b0};
      adv_r    = pr_ff + sr_ff;
      phase32  = 32'(pq_ff) << (32 - A);
      quad_in  = 2'((phase32 + 32'h2000_0000) >> 30);
      resid    = phase32 - {quad_in, 30'd0};
      dx       = y_ff >>> iter_ff;
      dy       = x_ff >>> iter_ff;
      atan_s   = $signed({4'd0, spvg_pkg::atan_turn(iter_ff)});
      case (quad_ff)
         2'd0: begin c_val = x_ff;  s_val = y_ff;  end
         2'd1: begin c_val = -y_ff; s_val = x_ff;  end
         2'd2: begin c_val = -x_ff; s_val = -y_ff; end
         default: begin c_val = y_ff; s_val = -x_ff; end
      endcase
      radius_s = $signed({2'b00, (j_ff[0] ? desc_ff.tip_radius : desc_ff.valley_radius)});
      rnd_x    = (pc_ff + PW'(64'sd536870912)) >>> 30;
      rnd_y    = (ps_ff + PW'(64'sd536870912)) >>> 30;
      sum_x    = {{5{desc_ff.center_x[23]}}, desc_ff.center_x} + {rnd_x[27], rnd_x[27:0]};
      sum_y    = {{5{desc_ff.center_y[23]}}, desc_ff.center_y} + {rnd_y[27], rnd_y[27:0]};
      if (sum_x > spvg_pkg::COORD_MAX) begin
         sat_x = 24'sh7FFFFF;
      end else if (sum_x < spvg_pkg::COORD_MIN) begin
         sat_x = -24'sh800000;
      end else begin
         sat_x = sum_x[23:0];
      end
      if (sum_y > spvg_pkg::COORD_MAX) begin
         sat_y = 24'sh7FFFFF;
      end else if (sum_y < spvg_pkg::COORD_MIN) begin
         sat_y = -24'sh800000;
      end else begin
         sat_y = sum_y[23:0];
      end
      is_last = ({1'b0, j_ff} == ({desc_ff.point_count, 1'b0} - 7'd1));
   end

   assign q_pop = (state_ff == B_IDLE) && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  desc_ff <= q_desc;
                  sq_ff   <= q_step_q;
                  sr_ff   <= q_step_r;
                  j_ff    <= '0;
                  if (init_r >= {q_desc.point_count, 2'b00}) begin
                     pr_ff <= init_r - {q_desc.point_count, 2'b00};
                     pq_ff <= A'(q_step_q) + A'(1);
                  end else begin
                     pr_ff <= init_r;
                     pq_ff <= A'(q_step_q);
                  end
                  state_ff <= B_PREP;
               end
            end
            B_PREP: begin
               x_ff     <= spvg_pkg::INV_GAIN;
               y_ff     <= '0;
               z_ff     <= $signed({{2{resid[31]}}, resid});
               quad_ff  <= quad_in;
               iter_ff  <= '0;
               state_ff <= B_ROT;
            end
            B_ROT: begin
               if (!z_ff[TW-1]) begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - atan_s;
               end else begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + atan_s;
               end
               if (iter_ff < 5'd2) begin
                  if (adv_r >= den4) begin
                     pr_ff <= adv_r - den4;
                     pq_ff <= pq_ff + A'(sq_ff) + A'(1);
                  end else begin
                     pr_ff <= adv_r;
                     pq_ff <= pq_ff + A'(sq_ff);
                  end
               end
               iter_ff <= iter_ff + 5'd1;
               if (iter_ff == 5'(spvg_pkg::CORDIC_ITERS - 1)) begin
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               pc_ff    <= PW'(radius_s) * PW'(c_val);
               ps_ff    <= PW'(radius_s) * PW'(s_val);
               state_ff <= B_SUM;
            end
            B_SUM: begin
               vx_ff     <= sat_x;
               vy_ff     <= sat_y;
               outer_ff  <= j_ff[0];
               last_ff   <= is_last;
               strobe_ff <= 1'b1;
               j_ff      <= j_ff + NW'(1);
               state_ff  <= is_last ? B_IDLE : B_PREP;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_vertex_x    = vx_ff;
   assign rsp_vertex_y    = vy_ff;
   assign rsp_is_outer    = outer_ff;
   assign rsp_last_vertex = last_ff;
endmodule
`default_nettype wire

FILE: hdl/spvg_checker.sv
// Port-level checks for the star polygon vertex generator, bound to the top.
// Depends on star_polygon_vertex_generator_core_defines.svh.
`default_nettype none
`include "star_polygon_vertex_generator_core_defines.svh"
module spvg_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe,
   input wire logic rsp_is_outer,
   input wire logic rsp_last_vertex
);
   `SPVG_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SPVG_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe)
   `SPVG_ASSERT_NOW(a_last_outer, clock, reset, rsp_strobe && rsp_last_vertex, rsp_is_outer)
endmodule

bind star_polygon_vertex_generator_core spvg_checker u_spvg_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_is_outer    (rsp_is_outer),
   .rsp_last_vertex (rsp_last_vertex)
);
`default_nettype wire
